>>> hw/rtl/erhc_pkg.sv
package erhc_pkg;

   // Field widths fixed by the stream format.
   localparam int unsigned COL_W   = 32;
   localparam int unsigned VAL_W   = 64;
   localparam int unsigned DATA_W  = COL_W + VAL_W;
   localparam int unsigned CFG_W   = 31;
   localparam int unsigned RW_W    = 6;
   localparam int unsigned ADDR_W  = 2;

   // Configuration register indexes.
   localparam logic [ADDR_W-1:0] REG_LOCAL_ROWS = 2'd0;
   localparam logic [ADDR_W-1:0] REG_TOTAL_COLS = 2'd1;
   localparam logic [ADDR_W-1:0] REG_ROW_WIDTH  = 2'd2;

   // Reset value of the row width register.
   localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 6'd27;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_slot;   // load the output slot register
      logic load_pad;    // slot holds padding rather than the input entry
      logic slot_done;   // slot is the last one of its row
      logic kept_inc;    // one more slot given for this row
      logic kept_clear;  // row finished, restart the slot count
      logic pos_inc;     // advance to the next entry of the row
      logic pos_clear;   // last entry of the row seen
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic keep;        // entry is external and the row has room
      logic last;        // entry is the last of its row
      logic room;        // slot count is below the row width
      logic fill_next;   // the next slot given completes the row
   } dp_status_type;

endpackage

>>> hw/rtl/ell_row_halo_compaction.sv
// ELL row halo compaction.
// Entries of sparse rows in ELL form arrive on the req_ stream, one column
// index and 64-bit value per beat, row_width beats per row. An entry whose
// column lies in [local_rows, total_cols) leaves on the rsp_ stream, so kept
// entries of a row come out in order, packed to the front. After the row's
// last entry the block pads the row to row_width beats with column all ones
// and value zero, and raises rsp_tlast on the row's final beat.
// The user must write registers through the csr_ port only while the block
// is idle; the block itself does not enforce it. A kept entry is registered
// into the output slot and appears on rsp_ in the cycle after it is accepted.
// Throughput: one input beat per cycle while a row is streaming and the slot
// is free; at the end of a row the padding beats go out one per cycle while
// the slot is free, from the padding state of the controller, and req_tready
// stays low until the row's final padding beat is loaded.
// A single output slot register parts the two sides: when rsp_tready is low
// and the slot is full, req_tready drops and nothing is lost or repeated.
// Synchronous reset clears the row counters and the slot, sets local_rows
// and total_cols to zero and row_width to 27.
module ell_row_halo_compaction
   import erhc_pkg::*;
#(
   parameter int unsigned MAX_ROW_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // Configuration write port.
   input  logic                 csr_we,
   input  logic [ADDR_W-1:0]    csr_addr,
   input  logic [CFG_W-1:0]     csr_wdata,
   // Input entries.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // col [31:0], val [95:32]
   // Output slots.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // out_col [31:0], out_val [95:32]
   output logic                 rsp_tlast    // row_done
);

   dp_cmd_type    cmd;
   dp_status_type status;

   erhc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   erhc_datapath #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

>>> hw/rtl/erhc_datapath.sv
module erhc_datapath
   import erhc_pkg::*;
#(
   parameter int unsigned MAX_ROW_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [ADDR_W-1:0]    csr_addr,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [DATA_W-1:0]    req_tdata,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic [DATA_W-1:0]    rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int unsigned CW = $clog2(MAX_ROW_WIDTH + 1);
   localparam int unsigned XW = (CW > RW_W ? CW : RW_W) + 1;

   logic [CFG_W-1:0]  local_rows_ff, local_rows_in;
   logic [CFG_W-1:0]  total_cols_ff, total_cols_in;
   logic [RW_W-1:0]   row_width_ff, row_width_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     kept_ff, kept_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic              done_ff, done_in;

   logic [XW-1:0]     width_x;
   logic [CW-1:0]     width;
   logic [COL_W-1:0]  req_col;
   logic [VAL_W-1:0]  req_val;
   logic              in_range;

   assign req_col = req_tdata[COL_W-1:0];
   assign req_val = req_tdata[DATA_W-1:COL_W];

   // Effective row width, clamped to one through the largest supported width.
   always_comb begin
      width_x = XW'(row_width_ff);
      if (width_x == '0) begin
         width_x = XW'(1);
      end else if (width_x > XW'(MAX_ROW_WIDTH)) begin
         width_x = XW'(MAX_ROW_WIDTH);
      end
      width = width_x[CW-1:0];
   end

   // A negative column is below every local row count and is dropped.
   assign in_range = !req_col[COL_W-1]
                   && (req_col[CFG_W-1:0] >= local_rows_ff)
                   && (req_col[CFG_W-1:0] < total_cols_ff);

   always_comb begin
      status.room      = kept_ff < width;
      status.keep      = in_range && status.room;
      status.last      = ({1'b0, pos_ff} + (CW+1)'(1)) >= {1'b0, width};
      status.fill_next = ({1'b0, kept_ff} + (CW+1)'(1)) >= {1'b0, width};
   end

   always_comb begin
      local_rows_in = local_rows_ff;
      total_cols_in = total_cols_ff;
      row_width_in  = row_width_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_LOCAL_ROWS: local_rows_in = csr_wdata;
            REG_TOTAL_COLS: total_cols_in = csr_wdata;
            REG_ROW_WIDTH:  row_width_in  = csr_wdata[RW_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_clear) begin
         pos_in = '0;
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + CW'(1);
      end
      kept_in = kept_ff;
      if (cmd.kept_clear) begin
         kept_in = '0;
      end else if (cmd.kept_inc) begin
         kept_in = kept_ff + CW'(1);
      end
   end

   always_comb begin
      col_in  = col_ff;
      val_in  = val_ff;
      done_in = done_ff;
      if (cmd.load_slot) begin
         col_in  = cmd.load_pad ? '1 : req_col;
         val_in  = cmd.load_pad ? '0 : req_val;
         done_in = cmd.slot_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_rows_ff <= '0;
         total_cols_ff <= '0;
         row_width_ff  <= ROW_WIDTH_RESET;
         pos_ff        <= '0;
         kept_ff       <= '0;
      end else begin
         local_rows_ff <= local_rows_in;
         total_cols_ff <= total_cols_in;
         row_width_ff  <= row_width_in;
         pos_ff        <= pos_in;
         kept_ff       <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      val_ff  <= val_in;
      done_ff <= done_in;
   end

   assign rsp_tdata = {val_ff, col_ff};
   assign rsp_tlast = done_ff;

endmodule

>>> hw/rtl/erhc_ctrl.sv
module erhc_ctrl
   import erhc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_PAD  = 1'b1;

   logic state_ff, state_in;
   logic valid_ff, valid_in;
   logic slot_free;
   logic accept;

   // The slot register can take a new beat when empty or being drained.
   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_slot = status.keep;
               cmd.slot_done = status.last && status.fill_next;
               cmd.kept_inc  = status.keep;
               if (status.last) begin
                  cmd.pos_clear = 1'b1;
                  if (status.keep ? !status.fill_next : status.room) begin
                     state_in = S_PAD;
                  end else begin
                     cmd.kept_clear = 1'b1;
                  end
               end else begin
                  cmd.pos_inc = 1'b1;
               end
            end
         end
         S_PAD: begin
            if (slot_free) begin
               cmd.load_slot = 1'b1;
               cmd.load_pad  = 1'b1;
               cmd.slot_done = status.fill_next;
               if (status.fill_next) begin
                  cmd.kept_clear = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.kept_inc = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_slot) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> test/erhc_checker.sv
module erhc_checker
   import erhc_pkg::*;
#(
   parameter int unsigned MAX_ROW_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // col [31:0], val [95:32]
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,   // out_col [31:0], out_val [95:32]
   input  logic              rsp_tlast,   // row_done
   output int                mismatch_count,
   output int                slots_pending,
   output int                beats_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] val;
      logic             done;
   } out_slot_type;

   out_slot_type     slot_queue[$];
   logic [CFG_W-1:0] local_rows;
   logic [CFG_W-1:0] total_cols;
   logic [RW_W-1:0]  row_width;
   logic [4:0]       entry_pos;
   logic [5:0]       kept_count;
   int               mismatches;
   int               checked;

   // Out-of-range widths are pulled into 1 .. MAX_ROW_WIDTH.
   function automatic int unsigned clamp_width(logic [RW_W-1:0] rw);
      if (rw == 0) return 1;
      if (rw > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
      return rw;
   endfunction

   // Works out the output slots caused by one entry and advances the row state.
   // A row whose slots are already full when it ends gets no padding at all.
   task automatic compact_entry(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val);
      int unsigned w;
      int unsigned kept;
      int unsigned pads;
      bit          last;
      bit          keep;
      w    = clamp_width(row_width);
      kept = kept_count;
      last = (entry_pos + 1 >= w);
      keep = $signed(col) >= $signed({1'b0, local_rows}) &&
             $signed(col) < $signed({1'b0, total_cols}) && kept < w;
      if (keep) kept++;
      pads = (last && kept < w) ? w - kept : 0;
      if (keep) slot_queue.push_back('{col: col, val: val, done: last && pads == 0});
      for (int unsigned i = 0; i < pads; i++) begin
         slot_queue.push_back('{col: {COL_W{1'b1}}, val: '0, done: i == pads - 1});
      end
      if (last) begin
         entry_pos  = '0;
         kept_count = '0;
      end else begin
         entry_pos  = entry_pos + 1'b1;
         kept_count = 6'(kept);
      end
   endtask

   always @(posedge clock) begin
      out_slot_type exp_slot;
      if (reset) begin
         local_rows = '0;
         total_cols = '0;
         row_width  = ROW_WIDTH_RESET;
         entry_pos  = '0;
         kept_count = '0;
         mismatches = 0;
         checked    = 0;
         slot_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (slot_queue.size() == 0) begin
               $error("unexpected result beat: out_col %0d out_val %h row_done %b",
                      $signed(rsp_tdata[COL_W-1:0]), rsp_tdata[DATA_W-1:COL_W], rsp_tlast);
               mismatches++;
            end else begin
               exp_slot = slot_queue.pop_front();
               if (rsp_tdata[COL_W-1:0] !== exp_slot.col) begin
                  $error("out_col mismatch: expected %0d, actual %0d",
                         $signed(exp_slot.col), $signed(rsp_tdata[COL_W-1:0]));
                  mismatches++;
               end
               if (rsp_tdata[DATA_W-1:COL_W] !== exp_slot.val) begin
                  $error("out_val mismatch: expected %h, actual %h",
                         exp_slot.val, rsp_tdata[DATA_W-1:COL_W]);
                  mismatches++;
               end
               if (rsp_tlast !== exp_slot.done) begin
                  $error("row_done mismatch: expected %b, actual %b", exp_slot.done, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            compact_entry(req_tdata[COL_W-1:0], req_tdata[DATA_W-1:COL_W]);
         end
         if (csr_we) begin
            case (csr_addr)
               REG_LOCAL_ROWS: local_rows = csr_wdata;
               REG_TOTAL_COLS: total_cols = csr_wdata;
               REG_ROW_WIDTH:  row_width  = csr_wdata[RW_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= mismatches;
      slots_pending  <= slot_queue.size();
      beats_checked  <= checked;
   end

endmodule

>>> test/tb_ell_row_halo_compaction.sv
module tb_ell_row_halo_compaction;
   import erhc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_ROW_WIDTH = 32;
   // Index with no register behind it; writes to it must change nothing.
   localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [CFG_W-1:0]  CFG_MAX    = {CFG_W{1'b1}};
   localparam int IDLE_PCT      = 13;
   // Cycles allowed after the last expected beat, for entries that cause no beat.
   localparam int DRAIN_CYCLES  = 4;
   localparam int RANDOM_ITEMS  = 180;
   // Window of entries, counted after the first 20 sent, in which neither side idles.
   localparam int CALM_FROM     = 110;
   localparam int CALM_TO       = 170;
   // Entry count at which the receiver starts its long hold-off.
   localparam int HOLD_AT       = 70;
   localparam int HOLD_CYCLES   = 60;
   localparam int QUIET_LIMIT   = 1000;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [ADDR_W-1:0] csr_addr;
   logic [CFG_W-1:0]  csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;   // col [31:0], val [95:32]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;   // out_col [31:0], out_val [95:32]
   logic              rsp_tlast;   // row_done

   int mismatch_count;
   int slots_pending;
   int beats_checked;

   // Stimulus bookkeeping: what the block is currently configured with.
   logic [CFG_W-1:0] cur_lr;
   logic [CFG_W-1:0] cur_tc;
   logic [RW_W-1:0]  cur_rw;
   int               entries_sent;
   int               settings_used;
   int               target_entries;

   // Shared with the receiver: calm turns idling off, hold_request starts the hold-off.
   logic calm;
   logic hold_request;
   int   hold_left = 0;
   bit   hold_done = 0;
   int   quiet_cycles = 0;

   ell_row_halo_compaction #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   erhc_checker #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .slots_pending  (slots_pending),
      .beats_checked  (beats_checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The receiver. Normally it stalls at random; inside the calm window it
   // always accepts. Once the sender asks, it holds off for a long stretch,
   // counting the cycles here, so the single output slot fills and the block
   // has to push back on its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog: a run that stops moving beats in either direction is stuck.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_ell_row_halo_compaction: done, errors");
         $finish;
      end
   end

   // Writes all registers in a row, the width index with random upper bits
   // that the block must ignore, then the unused index.
   task automatic apply_settings(input logic [CFG_W-1:0] lr, input logic [CFG_W-1:0] tc,
                                 input logic [RW_W-1:0] rw);
      cur_lr = lr;
      cur_tc = tc;
      cur_rw = rw;
      settings_used++;
      csr_we    <= 1'b1;
      csr_addr  <= REG_LOCAL_ROWS;
      csr_wdata <= lr;
      @(posedge clock);
      csr_addr  <= REG_TOTAL_COLS;
      csr_wdata <= tc;
      @(posedge clock);
      csr_addr  <= REG_ROW_WIDTH;
      csr_wdata <= CFG_W'(($urandom() << RW_W) | rw);
      @(posedge clock);
      csr_addr  <= REG_UNUSED;
      csr_wdata <= CFG_W'($urandom());
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Stops offering and waits until every expected beat has left, plus a few
   // cycles for an entry that was dropped and is still on its way through.
   // The first edge lets the checker count the beat accepted just now.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (slots_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offers one entry, after a random gap unless in the calm window, and
   // returns in the time step of the edge that accepted it.
   task automatic send_entry(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val);
      bit in_calm;
      in_calm = entries_sent - 20 >= CALM_FROM && entries_sent - 20 < CALM_TO;
      calm         <= in_calm;
      hold_request <= (entries_sent >= HOLD_AT);
      while (!in_calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      entries_sent++;
   endtask

   // Columns: many inside the external range, plenty of unused slots, the
   // edges of the range on both sides, raw 32-bit noise and small columns up to 1000.
   function automatic logic [COL_W-1:0] pick_col();
      int unsigned roll;
      int unsigned span;
      roll = $urandom_range(0, 99);
      span = cur_tc - cur_lr;
      if (roll < 45 && cur_tc > cur_lr) return COL_W'(cur_lr) + $urandom_range(0, span - 1);
      if (roll < 60) return '1;
      if (roll < 70) return $urandom();
      if (roll < 85) begin
         case ($urandom_range(0, 3))
            0: return COL_W'(cur_lr) - 1;
            1: return COL_W'(cur_lr);
            2: return COL_W'(cur_tc) - 1;
            default: return COL_W'(cur_tc);
         endcase
      end
      return $urandom_range(0, 1000);
   endfunction

   function automatic logic [VAL_W-1:0] pick_val();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      int unsigned w;
      int unsigned n;
      int unsigned lr;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_addr     <= REG_LOCAL_ROWS;
      csr_wdata    <= '0;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      calm         <= 1'b0;
      hold_request <= 1'b0;
      entries_sent  = 0;
      settings_used = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Widest external range: column zero and the largest valid column are
      // kept, while -1, the most negative column and a column equal to
      // total_cols are dropped. The row of five ends in three padding beats.
      apply_settings('0, CFG_MAX, 6'd5);
      send_entry(32'd0, '1);
      send_entry('1, pick_val());
      send_entry(32'h7FFF_FFFE, '0);
      send_entry(32'h8000_0000, pick_val());
      send_entry(32'h7FFF_FFFF, pick_val());
      wait_drained();

      // A width of zero behaves as one: every entry is its own row, kept at
      // both ends of [10, 20) and replaced by padding just outside it.
      apply_settings(31'd10, 31'd20, 6'd0);
      send_entry(32'd10, pick_val());
      send_entry(32'd19, pick_val());
      send_entry(32'd20, pick_val());
      send_entry(32'd9, pick_val());
      wait_drained();

      // Empty external range: nothing can be kept, the row is all padding.
      apply_settings(31'd30, 31'd30, 6'd2);
      send_entry(32'd30, pick_val());
      send_entry(32'd31, pick_val());
      wait_drained();

      // Width lowered in the middle of a row that already has more kept
      // beats than the new width: the next entry ends the row with no beat
      // and no row_done mark at all.
      apply_settings('0, CFG_MAX, 6'd8);
      repeat (5) send_entry($urandom_range(0, 1000), pick_val());
      wait_drained();
      apply_settings('0, CFG_MAX, 6'd3);
      send_entry(32'd42, pick_val());
      wait_drained();

      // Width lowered while the row still has room: the next entry is kept
      // and closes the row itself.
      apply_settings('0, CFG_MAX, 6'd8);
      send_entry(32'd5, pick_val());
      send_entry('1, pick_val());
      wait_drained();
      apply_settings('0, CFG_MAX, 6'd2);
      send_entry(32'd7, pick_val());

      // Random phases: each picks a setting, sends whole rows, and now and
      // then a partial row, so the next width change lands mid-row.
      target_entries = entries_sent + RANDOM_ITEMS;
      while (entries_sent < target_entries) begin
         wait_drained();
         case ($urandom_range(0, 9))
            0: begin
               lr = $urandom_range(0, 1000);
               apply_settings(CFG_W'(lr), CFG_W'($urandom_range(0, lr)), cur_rw);
            end
            1: apply_settings('0, CFG_MAX, cur_rw);
            2: apply_settings(CFG_MAX - CFG_W'($urandom_range(0, 500)), CFG_MAX, cur_rw);
            3: apply_settings('0, '0, cur_rw);
            default: begin
               lr = $urandom_range(0, 200);
               apply_settings(CFG_W'(lr), CFG_W'(lr + $urandom_range(1, 300)), cur_rw);
            end
         endcase
         wait_drained();
         case ($urandom_range(0, 19))
            0: cur_rw = 6'd0;
            1: cur_rw = 6'd32;
            2: cur_rw = RW_W'($urandom_range(33, 63));
            3: cur_rw = RW_W'($urandom_range(9, 31));
            default: cur_rw = RW_W'($urandom_range(1, 8));
         endcase
         apply_settings(cur_lr, cur_tc, cur_rw);
         w = (cur_rw == 0) ? 1 : (cur_rw > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : cur_rw;
         n = w * ((w > 8) ? 1 : $urandom_range(1, 4));
         if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w);
         repeat (n) send_entry(pick_col(), pick_val());
      end
      wait_drained();

      $display("Sent %0d entries under %0d register settings and checked %0d result beats.",
               entries_sent, settings_used, beats_checked);
      $display("Covered empty and full external ranges, out-of-range widths, mid-row width "
               , "changes and a long output stall.");
      if (mismatch_count == 0 && slots_pending == 0) begin
         $display("tb_ell_row_halo_compaction: done, clean");
      end else begin
         $display("tb_ell_row_halo_compaction: done, errors");
      end
      $finish;
   end

endmodule
